// ===== sv/mbac_pkg.sv =====
`default_nettype none

package mbac_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CH_BITS    = 8;
  localparam int unsigned SUM_BITS   = 32;
  localparam int unsigned TALLY_BITS = 24;
  localparam int unsigned REM_BITS   = SUM_BITS + 1;
  localparam int unsigned DVS_BITS   = TALLY_BITS + CH_BITS - 1;
  localparam int unsigned QBIT_BITS  = $clog2(CH_BITS);

  localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};
  localparam logic [CH_BITS-1:0]    MASK_FULL = {CH_BITS{1'b1}};

  typedef enum logic [1:0] {
    CFG_BOX_LEFT   = 2'd0,
    CFG_BOX_TOP    = 2'd1,
    CFG_BOX_WIDTH  = 2'd2,
    CFG_BOX_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [CH_BITS-1:0]    pixel_blue;
    logic [CH_BITS-1:0]    pixel_green;
    logic [CH_BITS-1:0]    pixel_red;
    logic [CH_BITS-1:0]    mask_level;
    logic                  frame_end;
  } pix_t;

  typedef struct packed {
    logic [CH_BITS-1:0]    mean_blue;
    logic [CH_BITS-1:0]    mean_green;
    logic [CH_BITS-1:0]    mean_red;
    logic [TALLY_BITS-1:0] selected_count;
    logic                  region_empty;
  } res_t;

  // finished frame totals handed from front to back
  typedef struct packed {
    logic [SUM_BITS-1:0]   sum_blue;
    logic [SUM_BITS-1:0]   sum_green;
    logic [SUM_BITS-1:0]   sum_red;
    logic [TALLY_BITS-1:0] pixel_tally;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_DONE
  } bk_state_e;

endpackage

`default_nettype wire

// ===== sv/mbac_front.sv =====
`default_nettype none

module mbac_front import mbac_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire cfg_idx_e              cfg_idx_i,
  input  wire logic [COORD_BITS-1:0] cfg_wdata_i,
  input  wire logic                  push_i,
  input  wire pix_t                  pix_i,
  output logic                       full_o,
  output logic                       job_push_o,
  output job_t                       job_o,
  input  wire logic                  job_full_i
);

  logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q;

  logic                  s1_valid_q;
  logic                  s1_sel_q, s1_last_q;
  logic [CH_BITS-1:0]    s1_b_q, s1_g_q, s1_r_q;

  logic [SUM_BITS-1:0]   sum_b_q, sum_g_q, sum_r_q;
  logic [SUM_BITS-1:0]   sum_b_nx, sum_g_nx, sum_r_nx;
  logic [TALLY_BITS-1:0] tally_q, tally_nx;

  logic [COORD_BITS:0]   x_end, y_end;
  logic                  x_in, y_in, sel;
  logic                  stall, accept, add;

  // box test, bounds one bit wider so they never wrap
  assign x_end = {1'b0, left_q} + {1'b0, width_q};
  assign y_end = {1'b0, top_q} + {1'b0, height_q};
  assign x_in  = (pix_i.pix_x >= left_q) && ({1'b0, pix_i.pix_x} < x_end);
  assign y_in  = (pix_i.pix_y >= top_q) && ({1'b0, pix_i.pix_y} < y_end);
  assign sel   = x_in && y_in && (pix_i.mask_level == MASK_FULL);

  assign stall  = s1_valid_q && s1_last_q && job_full_i;
  assign full_o = stall;
  assign accept = push_i && !stall;

  assign add      = s1_valid_q && s1_sel_q && (tally_q != TALLY_MAX);
  assign sum_b_nx = add ? sum_b_q + SUM_BITS'(s1_b_q) : sum_b_q;
  assign sum_g_nx = add ? sum_g_q + SUM_BITS'(s1_g_q) : sum_g_q;
  assign sum_r_nx = add ? sum_r_q + SUM_BITS'(s1_r_q) : sum_r_q;
  assign tally_nx = add ? tally_q + TALLY_BITS'(1) : tally_q;

  assign job_push_o        = s1_valid_q && s1_last_q && !job_full_i;
  assign job_o.sum_blue    = sum_b_nx;
  assign job_o.sum_green   = sum_g_nx;
  assign job_o.sum_red     = sum_r_nx;
  assign job_o.pixel_tally = tally_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOX_LEFT:   left_q   <= cfg_wdata_i;
        CFG_BOX_TOP:    top_q    <= cfg_wdata_i;
        CFG_BOX_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_BOX_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (!stall) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sel_q  <= sel;
      s1_last_q <= pix_i.frame_end;
      s1_b_q    <= pix_i.pixel_blue;
      s1_g_q    <= pix_i.pixel_green;
      s1_r_q    <= pix_i.pixel_red;
    end
  end

  // accumulators, cleared once the frame totals enter the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_b_q <= '0;
      sum_g_q <= '0;
      sum_r_q <= '0;
      tally_q <= '0;
    end else if (job_push_o) begin
      sum_b_q <= '0;
      sum_g_q <= '0;
      sum_r_q <= '0;
      tally_q <= '0;
    end else if (s1_valid_q && !s1_last_q) begin
      sum_b_q <= sum_b_nx;
      sum_g_q <= sum_g_nx;
      sum_r_q <= sum_r_nx;
      tally_q <= tally_nx;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mbac_fifo.sv =====
`default_nettype none

module mbac_fifo import mbac_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mbac_back.sv =====
`default_nettype none

module mbac_back import mbac_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic job_empty_i,
  output logic      job_pop_o,
  output res_t      res_o,
  output logic      empty_o,
  input  wire logic pop_i
);

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  bk_state_e            state_q, state_d;
  job_t                 job_q;
  logic [1:0]           ch_q;
  logic [QBIT_BITS-1:0] bit_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [DVS_BITS-1:0]  dvs_q;
  logic [CH_BITS-1:0]   quo_q, quo_nx;
  logic [CH_BITS-1:0]   mean_b_q, mean_g_q, mean_r_q;
  res_t                 out_q;
  logic                 out_valid_q;

  logic                 do_load, do_step, do_emit, tally_zero, ge;
  logic [SUM_BITS-1:0]  sum_sel;

  assign tally_zero = (job_q.pixel_tally == '0);
  assign ge         = (rem_q >= REM_BITS'(dvs_q));
  assign quo_nx     = {quo_q[CH_BITS-2:0], ge};

  always_comb begin
    case (ch_q)
      CH_BLUE:  sum_sel = job_q.sum_blue;
      CH_GREEN: sum_sel = job_q.sum_green;
      default:  sum_sel = job_q.sum_red;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!job_empty_i) state_d = BK_LOAD;
      BK_LOAD: state_d = tally_zero ? BK_DONE : BK_DIV;
      BK_DIV: begin
        if (bit_q == '0) begin
          state_d = (ch_q == CH_RED) ? BK_DONE : BK_LOAD;
        end
      end
      BK_DONE: if (!out_valid_q || pop_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    do_load   = 1'b0;
    do_step   = 1'b0;
    do_emit   = 1'b0;
    unique case (state_q)
      BK_IDLE: job_pop_o = !job_empty_i;
      BK_LOAD: do_load   = !tally_zero;
      BK_DIV:  do_step   = 1'b1;
      BK_DONE: do_emit   = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ch_q        <= CH_BLUE;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        ch_q <= CH_BLUE;
      end else if (do_step && bit_q == '0) begin
        ch_q <= ch_q + 2'd1;
      end
      if (do_load) begin
        bit_q <= QBIT_BITS'(CH_BITS - 1);
      end else if (do_step) begin
        bit_q <= bit_q - QBIT_BITS'(1);
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // one restoring step per cycle, divisor walks down from n << 7
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (do_load) begin
      rem_q <= REM_BITS'(sum_sel) + REM_BITS'(job_q.pixel_tally >> 1);
      dvs_q <= DVS_BITS'(job_q.pixel_tally) << (CH_BITS - 1);
      quo_q <= '0;
    end else if (do_step) begin
      rem_q <= ge ? rem_q - REM_BITS'(dvs_q) : rem_q;
      dvs_q <= dvs_q >> 1;
      quo_q <= quo_nx;
      if (bit_q == '0) begin
        case (ch_q)
          CH_BLUE:  mean_b_q <= quo_nx;
          CH_GREEN: mean_g_q <= quo_nx;
          default:  mean_r_q <= quo_nx;
        endcase
      end
    end
    if (do_emit) begin
      if (tally_zero) begin
        out_q.mean_blue      <= '0;
        out_q.mean_green     <= '0;
        out_q.mean_red       <= '0;
        out_q.selected_count <= '0;
        out_q.region_empty   <= 1'b1;
      end else begin
        out_q.mean_blue      <= mean_b_q;
        out_q.mean_green     <= mean_g_q;
        out_q.mean_red       <= mean_r_q;
        out_q.selected_count <= job_q.pixel_tally;
        out_q.region_empty   <= 1'b0;
      end
    end
  end

  assign res_o   = out_q;
  assign empty_o = !out_valid_q;

endmodule

`default_nettype wire

// ===== sv/masked_box_average_color_core.sv =====
// masked box average color
// input queue port: push a pixel word (coordinates, blue/green/red, mask level,
// frame_end flag) while full is low; one word per cycle is taken in steady state
// a pixel counts when it lies in the configured box and its mask level is 255
// config port: cfg_we_i with cfg_idx_i (left, top, width, height) and
// cfg_wdata_i, one register per write; write only while the block is idle
// result queue port: a result word sits on res_o while empty is low and is taken
// by pop; one result word per frame, on the word that carries frame_end
// the result word on res_o comes from the back end's shared divider, which per
// channel does one setup step and then 8 quotient bits; an empty region skips
// the division
// throughput: one pixel word per cycle; a frame whose results still wait in the
// back end parks in a queue of JOB_DEPTH frame totals, and full rises only when
// a frame-end word finds that queue full
// a stalled receiver holds the result word; the back end then stops and the
// totals queue fills, after which the front end stalls on the next frame end
// reset clears the box registers to zero, the sums and count, both queues
`default_nettype none

module masked_box_average_color_core import mbac_pkg::*; #(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire cfg_idx_e              cfg_idx_i,
  input  wire logic [COORD_BITS-1:0] cfg_wdata_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire pix_t                  pix_i,
  output logic                       empty,
  input  wire logic                  pop,
  output res_t                       res_o
);

  // frame totals from front end to divider
  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  mbac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .pix_i       (pix_i),
    .full_o      (full),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  mbac_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // rounded means by a shared restoring divider, then the result register
  mbac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

`ifndef SYNTHESIS
  // input stalls only because the totals queue cannot take a frame end
  a_full_needs_job_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> job_full)
    else $error("full without a full totals queue");

  // back end never takes totals from an empty queue
  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("totals popped from empty queue");

  // empty region word carries zero count and zero means
  a_empty_region_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.region_empty) |-> (res_o.selected_count == '0 &&
      res_o.mean_blue == '0 && res_o.mean_green == '0 && res_o.mean_red == '0))
    else $error("empty region word with nonzero fields");

  // a non-empty region word has a nonzero count
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.region_empty) |-> (res_o.selected_count != '0))
    else $error("selected word with zero count");
`endif

endmodule

`default_nettype wire

// ===== tb/masked_box_average_color_core_tb.sv =====
`timescale 1ns / 100ps

module masked_box_average_color_core_tb;
  import mbac_pkg::*;

  // a few divider passes with both totals slots busy
  localparam int unsigned SETTLE_CYCLES = 120;
  // random pixel words per random phase
  localparam int unsigned PHASE_WORDS   = 165;

  // dut ports, inputs known from time zero
  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_e              cfg_idx   = CFG_BOX_LEFT;
  logic [COORD_BITS-1:0] cfg_wdata = '0;
  logic                  pix_push  = 1'b0;
  logic                  pix_full;
  pix_t                  pix_word  = '0;
  logic                  res_empty;
  logic                  res_pop   = 1'b0;
  res_t                  res_word;

  // pixel words waiting for the driver, and means still owed by the dut
  pix_t pix_q[$];
  res_t mean_q[$];

  // predictor copy of the box registers and the frame totals
  logic [COORD_BITS-1:0] box_l = '0;
  logic [COORD_BITS-1:0] box_t = '0;
  logic [COORD_BITS-1:0] box_w = '0;
  logic [COORD_BITS-1:0] box_h = '0;
  logic [SUM_BITS-1:0]   acc_blue  = '0;
  logic [SUM_BITS-1:0]   acc_green = '0;
  logic [SUM_BITS-1:0]   acc_red   = '0;
  logic [TALLY_BITS-1:0] acc_tally = '0;

  // handshake bookkeeping
  logic        pix_taken = 1'b0;
  int unsigned push_gap  = 0;
  int unsigned pop_gap   = 0;
  bit          idle_on   = 1'b1;

  // run statistics
  int unsigned errors      = 0;
  int unsigned pix_count   = 0;
  int unsigned frames_done = 0;
  int unsigned n_settings  = 0;

  // tb-side copy of the box currently programmed, used to aim coordinates
  int unsigned cur_l = 0;
  int unsigned cur_t = 0;
  int unsigned cur_w = 0;
  int unsigned cur_h = 0;

  masked_box_average_color_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .push        (pix_push),
    .full        (pix_full),
    .pix_i       (pix_word),
    .empty       (res_empty),
    .pop         (res_pop),
    .res_o       (res_word)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // rounded channel mean, (sum + n/2) / n, low 8 bits
  function automatic logic [CH_BITS-1:0] round_mean(input logic [SUM_BITS-1:0] s,
                                                   input logic [TALLY_BITS-1:0] n);
    longint unsigned num;
    longint unsigned den;
    den = 64'(n);
    num = 64'(s) + 64'(n >> 1);
    return CH_BITS'(num / den);
  endfunction

  // fold one accepted pixel word into the frame totals; on frame end
  // produce the mean word and clear the totals
  function automatic bit fold_pixel(input pix_t p, output res_t r);
    logic [COORD_BITS:0] x_end;
    logic [COORD_BITS:0] y_end;
    bit                  hit;
    // box bounds are one bit wider so a box at the far edge does not wrap
    x_end = {1'b0, box_l} + {1'b0, box_w};
    y_end = {1'b0, box_t} + {1'b0, box_h};
    hit = (p.pix_x >= box_l) && ({1'b0, p.pix_x} < x_end) &&
          (p.pix_y >= box_t) && ({1'b0, p.pix_y} < y_end) &&
          (p.mask_level == MASK_FULL) && (acc_tally < TALLY_MAX);
    r = '0;
    if (hit) begin
      acc_blue  = acc_blue + SUM_BITS'(p.pixel_blue);
      acc_green = acc_green + SUM_BITS'(p.pixel_green);
      acc_red   = acc_red + SUM_BITS'(p.pixel_red);
      acc_tally = acc_tally + TALLY_BITS'(1);
    end
    if (!p.frame_end) return 1'b0;
    // nothing selected: zero means with the empty flag
    if (acc_tally == '0) begin
      r.region_empty = 1'b1;
    end else begin
      r.mean_blue      = round_mean(acc_blue, acc_tally);
      r.mean_green     = round_mean(acc_green, acc_tally);
      r.mean_red       = round_mean(acc_red, acc_tally);
      r.selected_count = acc_tally;
    end
    acc_blue  = '0;
    acc_green = '0;
    acc_red   = '0;
    acc_tally = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // pixel driver: holds a word until it is taken, idles in bursts
  always @(negedge clk) begin
    if (rst_n && (!pix_push || pix_taken)) begin
      if (push_gap != 0) begin
        pix_push <= 1'b0;
        push_gap <= push_gap - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        // idle burst that starts with this cycle, its length drawn at random
        pix_push <= 1'b0;
        push_gap <= $urandom_range(0, 12);
      end else if (pix_q.size() != 0) begin
        pix_push <= 1'b1;
        pix_word <= pix_q.pop_front();
      end else begin
        pix_push <= 1'b0;
      end
    end
  end

  // result side: stalls in bursts, otherwise always ready
  always @(negedge clk) begin
    if (rst_n) begin
      if (pop_gap != 0) begin
        res_pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_pop <= 1'b0;
        pop_gap <= $urandom_range(0, 12);
      end else begin
        res_pop <= 1'b1;
      end
    end
  end

  // monitor: tracks register writes, predicts on accepted pixels,
  // checks every accepted result word against the oldest prediction
  always @(posedge clk) begin : monitor
    res_t fresh;
    res_t want;
    if (!rst_n) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= pix_push && !pix_full;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BOX_LEFT:   box_l = cfg_wdata;
          CFG_BOX_TOP:    box_t = cfg_wdata;
          CFG_BOX_WIDTH:  box_w = cfg_wdata;
          CFG_BOX_HEIGHT: box_h = cfg_wdata;
          default: ;
        endcase
      end
      if (pix_push && !pix_full) begin
        pix_count++;
        if (fold_pixel(pix_word, fresh)) mean_q = {mean_q, fresh};
      end
      if (res_pop && !res_empty) begin
        if (mean_q.size() == 0) begin
          $error("result word with no frame end pending");
          errors++;
        end else begin
          want = mean_q.pop_front();
          frames_done++;
          check_field("mean_blue", want.mean_blue, res_word.mean_blue);
          check_field("mean_green", want.mean_green, res_word.mean_green);
          check_field("mean_red", want.mean_red, res_word.mean_red);
          check_field("selected_count", want.selected_count, res_word.selected_count);
          check_field("region_empty", want.region_empty, res_word.region_empty);
        end
      end
    end
  end

  function automatic pix_t mk_pix(input int unsigned x, input int unsigned y,
                                  input int unsigned b, input int unsigned g,
                                  input int unsigned r, input int unsigned m,
                                  input bit fe);
    pix_t p;
    p.pix_x       = x[COORD_BITS-1:0];
    p.pix_y       = y[COORD_BITS-1:0];
    p.pixel_blue  = b[CH_BITS-1:0];
    p.pixel_green = g[CH_BITS-1:0];
    p.pixel_red   = r[CH_BITS-1:0];
    p.mask_level  = m[CH_BITS-1:0];
    p.frame_end   = fe;
    return p;
  endfunction

  // coordinate mostly inside the span, some on its borders, some anywhere
  function automatic int unsigned pick_coord(input int unsigned start,
                                             input int unsigned len);
    int unsigned hi;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (len == 0 || sel >= 8) return $urandom_range(0, 4095);
    hi = start + len - 1;
    if (hi > 4095) hi = 4095;
    if (sel >= 6) begin
      case ($urandom_range(0, 3))
        0: return (start - 1) & 12'hfff;
        1: return start;
        2: return hi;
        default: return (start + len) & 12'hfff;
      endcase
    end
    return $urandom_range(start, hi);
  endfunction

  function automatic int unsigned pick_chan();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // append one word to the driver's pending queue
  function automatic void add_pix(input pix_t p);
    pix_q = {pix_q, p};
  endfunction

  task automatic set_box(input int unsigned l, input int unsigned t,
                         input int unsigned w, input int unsigned h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BOX_LEFT;
    cfg_wdata <= l[COORD_BITS-1:0];
    @(negedge clk);
    cfg_idx   <= CFG_BOX_TOP;
    cfg_wdata <= t[COORD_BITS-1:0];
    @(negedge clk);
    cfg_idx   <= CFG_BOX_WIDTH;
    cfg_wdata <= w[COORD_BITS-1:0];
    @(negedge clk);
    cfg_idx   <= CFG_BOX_HEIGHT;
    cfg_wdata <= h[COORD_BITS-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_l = l;
    cur_t = t;
    cur_w = w;
    cur_h = h;
    n_settings++;
  endtask

  // wait until every word went in and every mean came out, then let
  // the back end settle before the box may change
  task automatic drain();
    while (pix_q.size() != 0 || pix_push) @(posedge clk);
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frames(input int unsigned words);
    int unsigned sent;
    int unsigned n;
    int unsigned m;
    sent = 0;
    while (sent < words) begin
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
      for (int unsigned i = 0; i < n; i++) begin
        m = ($urandom_range(0, 3) != 0) ? 255 : $urandom_range(0, 255);
        add_pix(mk_pix(pick_coord(cur_l, cur_w), pick_coord(cur_t, cur_h),
                       pick_chan(), pick_chan(), pick_chan(), m, i == n - 1));
      end
      sent += n;
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // box still at reset: zero size, nothing selected
    add_pix(mk_pix(0, 0, 255, 255, 255, 255, 0));
    add_pix(mk_pix(4095, 4095, 0, 0, 0, 255, 1));
    drain();

    // box over the whole frame but the last row and column
    set_box(0, 0, 4095, 4095);
    add_pix(mk_pix(0, 0, 255, 0, 128, 255, 0));
    add_pix(mk_pix(4094, 4094, 0, 255, 1, 255, 0));
    add_pix(mk_pix(4095, 0, 7, 7, 7, 255, 0));     // right of box
    add_pix(mk_pix(0, 4095, 7, 7, 7, 255, 0));     // below box
    add_pix(mk_pix(10, 10, 9, 9, 9, 254, 0));      // mask just short
    add_pix(mk_pix(10, 10, 9, 9, 9, 0, 0));        // mask off
    add_pix(mk_pix(5, 5, 0, 0, 0, 255, 1));        // frame end counts too
    // rounding: half rounds up, a third rounds down
    add_pix(mk_pix(1, 1, 1, 1, 1, 255, 0));
    add_pix(mk_pix(2, 2, 0, 0, 0, 255, 1));
    add_pix(mk_pix(1, 1, 1, 1, 1, 255, 0));
    add_pix(mk_pix(2, 2, 0, 0, 0, 255, 0));
    add_pix(mk_pix(3, 3, 0, 0, 0, 255, 1));
    // lone frame end masked out, then a lone full-white pixel
    add_pix(mk_pix(1, 1, 200, 200, 200, 127, 1));
    add_pix(mk_pix(3000, 4000, 255, 255, 255, 255, 1));
    drain();

    // box at the far corner, its end lies past the coordinate range
    set_box(4095, 4095, 4095, 4095);
    add_pix(mk_pix(4095, 4095, 170, 85, 51, 255, 1));
    add_pix(mk_pix(4094, 4095, 170, 85, 51, 255, 1));
    drain();

    // random phases over a spread of boxes
    set_box($urandom_range(0, 4095), $urandom_range(0, 4095),
            $urandom_range(1, 64), $urandom_range(1, 64));
    random_frames(PHASE_WORDS);
    set_box($urandom_range(0, 4095), $urandom_range(0, 4095), 0, $urandom_range(1, 4095));
    random_frames(PHASE_WORDS);
    set_box($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 4095), 0);
    random_frames(PHASE_WORDS);
    set_box($urandom_range(4040, 4095), $urandom_range(4040, 4095),
            $urandom_range(1, 4095), $urandom_range(1, 80));
    random_frames(PHASE_WORDS);
    set_box(0, 0, 4095, 4095);
    random_frames(PHASE_WORDS);
    // last phase runs at full rate on both sides
    idle_on = 1'b0;
    set_box($urandom_range(0, 4000), $urandom_range(0, 4000),
            $urandom_range(1, 95), $urandom_range(1, 95));
    random_frames(PHASE_WORDS);

    if (mean_q.size() != 0) begin
      $error("%0d mean words never arrived", mean_q.size());
      errors++;
    end
    $display("ran %0d pixel words through %0d frames under %0d box settings",
             pix_count, frames_done, n_settings);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
